// ===== hdl/sra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_pkg
// Shared types and constants of the skyline rectangle allocator.
// ----------------------------------------------------------------------------
package sra_pkg;

	localparam int MAX_SEGMENTS = 64;
	localparam int MAX_DIM      = 4096;

	localparam int IDX_W   = $clog2(MAX_SEGMENTS);
	localparam int CNT_W   = $clog2(MAX_SEGMENTS + 2);
	localparam int ADDR_W  = IDX_W + 1;
	localparam int COORD_W = 13;
	localparam int SUM_W   = COORD_W + 1;
	localparam int POS_W   = 12;
	localparam int AREA_W  = 25;
	localparam int PROD_W  = 2 * COORD_W;

	localparam logic [COORD_W-1:0] DIM_MAX   = COORD_W'(MAX_DIM);
	localparam logic [COORD_W-1:0] RST_ATLAS = COORD_W'(512);
	localparam logic [AREA_W-1:0]  AREA_MAX  = {AREA_W{1'b1}};

	// request codes
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_NOFIT = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// configuration register indexes
	localparam logic REG_ATLAS_W = 1'b0;
	localparam logic REG_ATLAS_H = 1'b1;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] w;
	} seg_t;

	typedef struct packed {
		logic start;
		logic push;
		logic flush;
	} push_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TRY,
		ST_STEP,
		ST_BSTART,
		ST_BPRE,
		ST_BPREV,
		ST_BNEW,
		ST_BPOST,
		ST_BPOSTV,
		ST_BFLUSH,
		ST_BFIN,
		ST_CLR,
		ST_DONE
	} state_t;

endpackage

// ===== hdl/sra_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_if
// Request and result channels of the skyline rectangle allocator.
// ----------------------------------------------------------------------------
interface sra_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [12:0] req_width;
	logic [12:0] req_height;

	modport source (output valid, func, req_width, req_height, input ready);
	modport sink (input valid, func, req_width, req_height, output ready);
endinterface

interface sra_res_if;
	logic        valid;
	logic        ready;
	logic [11:0] pos_x;
	logic [11:0] pos_y;
	logic [1:0]  status;
	logic [24:0] used_area;

	modport source (output valid, pos_x, pos_y, status, used_area, input ready);
	modport sink (input valid, pos_x, pos_y, status, used_area, output ready);
endinterface

// ===== hdl/sra_seg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_seg_ram
// Two banks of skyline segments, one write and one registered read port.
// ----------------------------------------------------------------------------
module sra_seg_ram (
	input  logic                   clk,
	input  logic                   we,
	input  logic [sra_pkg::ADDR_W-1:0] waddr,
	input  sra_pkg::seg_t          wdata,
	input  logic [sra_pkg::ADDR_W-1:0] raddr,
	output sra_pkg::seg_t          rdata
);
	import sra_pkg::*;

	seg_t mem_q [2**ADDR_W];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/sra_push.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sra_push
// Builds the new segment list: holds the last segment back so that a
// neighbour of equal height merges into it, and counts the segments.
// ----------------------------------------------------------------------------
module sra_push (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sra_pkg::push_ctl_t        ctl,
	input  sra_pkg::seg_t             seg,
	output logic                      we,
	output logic [sra_pkg::IDX_W-1:0] widx,
	output sra_pkg::seg_t             wdata,
	output logic [sra_pkg::CNT_W-1:0] count
);
	import sra_pkg::*;

	localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(MAX_SEGMENTS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

	seg_t             pend_q;
	logic [CNT_W-1:0] n_q;
	logic             merge;
	logic [CNT_W-1:0] last;

	assign merge = (n_q != '0) && (pend_q.y == seg.y);
	assign last  = n_q - CNT_W'(1);
	assign count = n_q;
	assign widx  = last[IDX_W-1:0];
	assign wdata = pend_q;

	// pending segment goes out when a new one displaces it or on flush
	always_comb begin
		we = 1'b0;
		if (ctl.push && !merge && (n_q != '0) && (n_q < CNT_LIM)) begin
			we = 1'b1;
		end
		if (ctl.flush && (n_q != '0) && (n_q <= CNT_MAX)) begin
			we = 1'b1;
		end
	end

	// pending segment and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			pend_q <= '0;
		end else if (ctl.start) begin
			n_q <= '0;
		end else if (ctl.push) begin
			if (merge) begin
				pend_q.w <= pend_q.w + seg.w;
			end else if (n_q < CNT_LIM) begin
				pend_q <= seg;
				n_q    <= n_q + CNT_W'(1);
			end
		end
	end

endmodule

// ===== hdl/skyline_rect_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skyline_rect_allocator
// Skyline bottom-left rectangle allocator with a step-by-step sequencer.
// ----------------------------------------------------------------------------
// One request is taken at a time; ready is high only while the block idles.
// An allocation scans every segment as a left edge and walks the segments it
// would cover, one segment read per cycle through the single read port of
// the segment memory. The rebuild then reads each segment once, writing the
// new list into the other memory bank, which becomes current unless the list
// would overflow. The result waits in an output register until taken.
// ----------------------------------------------------------------------------
module skyline_rect_allocator (
	input  logic                   clk,
	input  logic                   arst_n,
	sra_req_if.sink                req,
	sra_res_if.source              res,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [12:0]            cfg_data
);
	import sra_pkg::*;

	// configuration
	logic [COORD_W-1:0] atlas_w_q, atlas_h_q;

	// sequencer state
	state_t             state_q, state_d;
	logic               bank_q, bank_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [AREA_W-1:0]  area_q, area_d;
	logic [COORD_W-1:0] rw_q, rw_d, rh_q, rh_d, aw_q, aw_d, ah_q, ah_d;
	logic [CNT_W-1:0]   i_q, i_d, j_q, j_d;
	logic [COORD_W-1:0] left_q, left_d, y_q, y_d, cw_q, cw_d, cx_q, cx_d;
	logic               found_q, found_d;
	logic [CNT_W-1:0]   idx_q, idx_d;
	logic [SUM_W-1:0]   btop_q, btop_d;
	logic [COORD_W-1:0] bw_q, bw_d, px_q, px_d, py_q, py_d;
	logic [SUM_W-1:0]   end_q, end_d;
	logic               trim_q, trim_d;
	logic [PROD_W-1:0]  prod_q, prod_d;
	logic [COORD_W-1:0] rx_q, rx_d, ry_q, ry_d;
	logic [1:0]         rst_q, rst_d;
	logic               v0_q, rd0_q;

	// output register
	logic               ovalid_q;
	logic [POS_W-1:0]   ox_q, oy_q;
	logic [1:0]         ost_q;
	logic [AREA_W-1:0]  oarea_q;
	logic               oload;

	// memory and push unit
	logic [ADDR_W-1:0]  raddr, waddr;
	logic               mwe;
	seg_t               mwdata, ram_rd, seg_rd;
	push_ctl_t          pctl;
	seg_t               pseg;
	logic               pwe;
	logic [IDX_W-1:0]   pidx;
	seg_t               pdata;
	logic [CNT_W-1:0]   pcount;

	// step arithmetic
	logic [COORD_W-1:0] ymax;
	logic [SUM_W-1:0]   top, xend, send;
	logic [CNT_W-1:0]   jn;
	logic [COORD_W-1:0] leftn;
	logic [AREA_W:0]    asum;
	logic [COORD_W-1:0] in_rw, in_rh;

	sra_seg_ram u_ram (
		.clk   (clk),
		.we    (mwe),
		.waddr (waddr),
		.wdata (mwdata),
		.raddr (raddr),
		.rdata (ram_rd)
	);

	sra_push u_push (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pctl),
		.seg    (pseg),
		.we     (pwe),
		.widx   (pidx),
		.wdata  (pdata),
		.count  (pcount)
	);

	// entry 0 of bank 0 reads as the reset segment until first written
	assign seg_rd = (rd0_q && !v0_q) ? seg_t'{x: '0, y: '0, w: RST_ATLAS} : ram_rd;

	assign ymax  = (seg_rd.y > y_q) ? seg_rd.y : y_q;
	assign top   = {1'b0, ymax} + {1'b0, rh_q};
	assign xend  = {1'b0, seg_rd.x} + {1'b0, rw_q};
	assign send  = {1'b0, seg_rd.x} + {1'b0, seg_rd.w};
	assign jn    = j_q + CNT_W'(1);
	assign leftn = (left_q > seg_rd.w) ? (left_q - seg_rd.w) : '0;
	assign asum  = {1'b0, area_q} + (AREA_W + 1)'(prod_q);
	assign in_rw = req.req_width;
	assign in_rh = req.req_height;

	assign req.ready = (state_q == ST_IDLE);
	assign oload     = (state_q == ST_DONE) && (!ovalid_q || res.ready);

	// sequencer next state and datapath control
	always_comb begin
		state_d = state_q;
		bank_d  = bank_q;
		cnt_d   = cnt_q;
		area_d  = area_q;
		rw_d    = rw_q;
		rh_d    = rh_q;
		aw_d    = aw_q;
		ah_d    = ah_q;
		i_d     = i_q;
		j_d     = j_q;
		left_d  = left_q;
		y_d     = y_q;
		cw_d    = cw_q;
		cx_d    = cx_q;
		found_d = found_q;
		idx_d   = idx_q;
		btop_d  = btop_q;
		bw_d    = bw_q;
		px_d    = px_q;
		py_d    = py_q;
		end_d   = end_q;
		trim_d  = trim_q;
		prod_d  = prod_q;
		rx_d    = rx_q;
		ry_d    = ry_q;
		rst_d   = rst_q;
		raddr   = {bank_q, i_q[IDX_W-1:0]};
		pctl    = '0;
		pseg    = seg_rd;
		mwe     = pwe;
		waddr   = {~bank_q, pidx};
		mwdata  = pdata;

		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					rw_d  = in_rw;
					rh_d  = in_rh;
					aw_d  = (atlas_w_q > DIM_MAX) ? DIM_MAX : atlas_w_q;
					ah_d  = (atlas_h_q > DIM_MAX) ? DIM_MAX : atlas_h_q;
					rx_d  = '0;
					ry_d  = '0;
					rst_d = STAT_NOFIT;
					i_d   = '0;
					found_d = 1'b0;
					if (req.func == FUNC_CLEAR) begin
						state_d = ST_CLR;
					end else if (in_rw == '0 || in_rw > DIM_MAX || in_rh > DIM_MAX) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_TRY;
					end
				end
			end
			// start a candidate left edge
			ST_TRY: begin
				if (i_q >= cnt_q) begin
					state_d = found_q ? ST_BSTART : ST_DONE;
				end else begin
					j_d     = i_q;
					left_d  = rw_q;
					y_d     = '0;
					state_d = ST_STEP;
				end
			end
			// walk the segments under the rectangle
			ST_STEP: begin
				if (j_q == i_q) begin
					cw_d = seg_rd.w;
					cx_d = seg_rd.x;
				end
				y_d    = ymax;
				left_d = leftn;
				j_d    = jn;
				if (((j_q == i_q) && (xend > {1'b0, aw_q})) || (top > {1'b0, ah_q})) begin
					i_d     = i_q + CNT_W'(1);
					state_d = ST_TRY;
				end else if (leftn == '0) begin
					if (!found_q || (top < btop_q) ||
					    ((top == btop_q) && (((j_q == i_q) ? seg_rd.w : cw_q) < bw_q))) begin
						found_d = 1'b1;
						idx_d   = i_q;
						btop_d  = top;
						bw_d    = (j_q == i_q) ? seg_rd.w : cw_q;
						py_d    = ymax;
						// x of the start segment, held since the first step
						px_d    = (j_q == i_q) ? seg_rd.x : cx_q;
					end
					i_d     = i_q + CNT_W'(1);
					state_d = ST_TRY;
				end else if (jn >= cnt_q) begin
					i_d     = i_q + CNT_W'(1);
					state_d = ST_TRY;
				end else begin
					raddr = {bank_q, jn[IDX_W-1:0]};
				end
			end
			ST_BSTART: begin
				pctl.start = 1'b1;
				i_d        = '0;
				state_d    = ST_BPRE;
			end
			// copy segments left of the placement
			ST_BPRE: begin
				state_d = (i_q == idx_q) ? ST_BNEW : ST_BPREV;
			end
			ST_BPREV: begin
				pctl.push = 1'b1;
				i_d       = i_q + CNT_W'(1);
				state_d   = ST_BPRE;
			end
			// the new top segment
			ST_BNEW: begin
				pctl.push = 1'b1;
				pseg      = '{x: px_q, y: py_q + rh_q, w: rw_q};
				end_d     = {1'b0, px_q} + {1'b0, rw_q};
				trim_d    = 1'b1;
				prod_d    = PROD_W'(rw_q) * PROD_W'(rh_q);
				i_d       = idx_q;
				state_d   = ST_BPOST;
			end
			ST_BPOST: begin
				state_d = (i_q >= cnt_q) ? ST_BFLUSH : ST_BPOSTV;
			end
			// trim or drop covered segments, copy the rest
			ST_BPOSTV: begin
				i_d     = i_q + CNT_W'(1);
				state_d = ST_BPOST;
				if (trim_q && ({1'b0, seg_rd.x} < end_q)) begin
					if (send > end_q) begin
						pctl.push = 1'b1;
						pseg      = '{x: end_q[COORD_W-1:0], y: seg_rd.y,
						              w: COORD_W'(send - end_q)};
						trim_d    = 1'b0;
					end
				end else begin
					trim_d    = 1'b0;
					pctl.push = 1'b1;
				end
			end
			ST_BFLUSH: begin
				pctl.flush = 1'b1;
				state_d    = ST_BFIN;
			end
			ST_BFIN: begin
				if (pcount > CNT_W'(MAX_SEGMENTS)) begin
					rst_d = STAT_FULL;
				end else begin
					bank_d = ~bank_q;
					cnt_d  = pcount;
					area_d = (asum > (AREA_W + 1)'(AREA_MAX)) ? AREA_MAX : asum[AREA_W-1:0];
					rst_d  = STAT_OK;
					rx_d   = px_q;
					ry_d   = py_q;
				end
				state_d = ST_DONE;
			end
			// single full-width segment in the current bank
			ST_CLR: begin
				mwe     = 1'b1;
				waddr   = {bank_q, {IDX_W{1'b0}}};
				mwdata  = '{x: '0, y: '0, w: aw_q};
				cnt_d   = CNT_W'(1);
				area_d  = '0;
				rst_d   = STAT_OK;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (oload) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bank_q  <= 1'b0;
			cnt_q   <= CNT_W'(1);
			area_q  <= '0;
			rw_q    <= '0;
			rh_q    <= '0;
			aw_q    <= '0;
			ah_q    <= '0;
			i_q     <= '0;
			j_q     <= '0;
			left_q  <= '0;
			y_q     <= '0;
			cw_q    <= '0;
			cx_q    <= '0;
			found_q <= 1'b0;
			idx_q   <= '0;
			btop_q  <= '0;
			bw_q    <= '0;
			px_q    <= '0;
			py_q    <= '0;
			end_q   <= '0;
			trim_q  <= 1'b0;
			prod_q  <= '0;
			rx_q    <= '0;
			ry_q    <= '0;
			rst_q   <= STAT_OK;
		end else begin
			state_q <= state_d;
			bank_q  <= bank_d;
			cnt_q   <= cnt_d;
			area_q  <= area_d;
			rw_q    <= rw_d;
			rh_q    <= rh_d;
			aw_q    <= aw_d;
			ah_q    <= ah_d;
			i_q     <= i_d;
			j_q     <= j_d;
			left_q  <= left_d;
			y_q     <= y_d;
			cw_q    <= cw_d;
			cx_q    <= cx_d;
			found_q <= found_d;
			idx_q   <= idx_d;
			btop_q  <= btop_d;
			bw_q    <= bw_d;
			px_q    <= px_d;
			py_q    <= py_d;
			end_q   <= end_d;
			trim_q  <= trim_d;
			prod_q  <= prod_d;
			rx_q    <= rx_d;
			ry_q    <= ry_d;
			rst_q   <= rst_d;
		end
	end

	// reset entry tracking for bank 0 entry 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q  <= 1'b0;
			rd0_q <= 1'b0;
		end else begin
			rd0_q <= (raddr == '0);
			if (mwe && (waddr == '0)) begin
				v0_q <= 1'b1;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_w_q <= RST_ATLAS;
			atlas_h_q <= RST_ATLAS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ATLAS_W: atlas_w_q <= cfg_data;
				REG_ATLAS_H: atlas_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			ox_q     <= '0;
			oy_q     <= '0;
			ost_q    <= STAT_OK;
			oarea_q  <= '0;
		end else begin
			if (oload) begin
				ovalid_q <= 1'b1;
				ox_q     <= rx_q[POS_W-1:0];
				oy_q     <= ry_q[POS_W-1:0];
				ost_q    <= rst_q;
				oarea_q  <= area_q;
			end else if (res.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign res.valid     = ovalid_q;
	assign res.pos_x     = ox_q;
	assign res.pos_y     = oy_q;
	assign res.status    = ost_q;
	assign res.used_area = oarea_q;

	// segment count stays within the store
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) && (cnt_q <= CNT_W'(MAX_SEGMENTS)))
		else $error("segment count out of range");

	// one request at a time
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while busy");

	// a full store leaves no position
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.status == STAT_FULL)) |-> ((res.pos_x == '0) && (res.pos_y == '0)))
		else $error("position reported with full status");

endmodule
